FILE: hdl/clbp_pkg.sv
// ----------------------------------------------------------------------------
// clbp_pkg
// types and constants shared by the cpu list to bit mask parser
// ----------------------------------------------------------------------------
package clbp_pkg;

    localparam int MASK_W = 64;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam int         RADIX    = 10;

    typedef enum logic [2:0] {
        PH_EXPECT_A,
        PH_IN_A,
        PH_EXPECT_B,
        PH_IN_B,
        PH_EXPECT_S,
        PH_IN_S
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } ctrl_t;

endpackage

FILE: hdl/cpu_list_to_bitmask_parser.sv
// ----------------------------------------------------------------------------
// cpu_list_to_bitmask_parser
// parses a cpu list string such as 0,2-3,0-20:2 into a cpu bit mask
//
// the input channel (in_valid / in_ready) takes one character per request,
// char_byte with last_char marking the final character of the list. a comma
// that closes a range, and the end of the list, start a range walk: the
// index adder steps from start by stride, one cpu index per cycle, over the
// listed indices below MAX_CPUS, with in_ready low meanwhile. after the
// final character and its walk the emit state loads the output register,
// whose request (out_valid / out_ready) carries list_ok and cpu_mask. a list
// with an error gives list_ok 0 and a zero mask. the output register holds
// a result while the receiver stalls and the parser goes on with the next
// list; only a second finished list waits in the emit state until the first
// is taken. reset clears the parser to the start of a new list with no
// output pending.
// ----------------------------------------------------------------------------
module cpu_list_to_bitmask_parser
    import clbp_pkg::*;
#(
    parameter int MAX_CPUS  = 64,
    parameter int NUM_WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        char_byte,
    input  logic              last_char,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              list_ok,
    output logic [MASK_W-1:0] cpu_mask
);

    localparam int IDX_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int ACC_W = NUM_WIDTH + 4;
    localparam int STP_W = NUM_WIDTH + 1;
    localparam logic [ACC_W-1:0] NUM_MAX = ACC_W'((64'(1) << NUM_WIDTH) - 64'(1));

    ctrl_t                state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [NUM_WIDTH-1:0] start_reg, start_next;
    logic [NUM_WIDTH-1:0] end_reg, end_next;
    logic [NUM_WIDTH-1:0] stride_reg, stride_next;
    logic [STP_W-1:0]     idx_reg, idx_next;
    logic [MASK_W-1:0]    mask_reg, mask_next;
    logic                 err_reg, err_next;
    logic                 junk_reg, junk_next;
    logic                 final_reg, final_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_ok_reg, out_ok_next;
    logic [MASK_W-1:0]    out_mask_reg, out_mask_next;

    logic                 is_digit;
    logic [3:0]           digit_val;
    logic [NUM_WIDTH-1:0] acc_in;
    logic [ACC_W-1:0]     acc_sum;
    logic [NUM_WIDTH-1:0] acc_sat;
    logic                 in_range;
    logic [STP_W-1:0]     idx_sum;

    assign is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    assign digit_val = is_digit ? 4'(char_byte - CH_ZERO) : 4'd0;

    always_comb
    begin
        unique case (phase_reg)
            PH_IN_A: acc_in = start_reg;
            PH_IN_B: acc_in = end_reg;
            default: acc_in = stride_reg;
        endcase
    end

    // times ten as shift and add, saturating
    assign acc_sum = (ACC_W'(acc_in) << 3) + (ACC_W'(acc_in) << 1) + ACC_W'(digit_val);
    assign acc_sat = (acc_sum > NUM_MAX) ? NUM_WIDTH'(NUM_MAX) : acc_sum[NUM_WIDTH-1:0];

    assign in_range = (idx_reg <= STP_W'(end_reg)) && (idx_reg < STP_W'(MAX_CPUS));
    assign idx_sum  = idx_reg + STP_W'(stride_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_EXPECT_A;
            start_reg     <= '0;
            end_reg       <= '0;
            stride_reg    <= NUM_WIDTH'(1);
            idx_reg       <= '0;
            mask_reg      <= '0;
            err_reg       <= 1'b0;
            junk_reg      <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_mask_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            stride_reg    <= stride_next;
            idx_reg       <= idx_next;
            mask_reg      <= mask_next;
            err_reg       <= err_next;
            junk_reg      <= junk_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
            out_ok_reg    <= out_ok_next;
            out_mask_reg  <= out_mask_next;
        end
    end

    always_comb
    begin
        logic comma_commit;
        logic do_commit;
        logic in_number;

        state_next     = state_reg;
        phase_next     = phase_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        stride_next    = stride_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        err_next       = err_reg;
        junk_next      = junk_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_mask_next  = out_mask_reg;
        comma_commit   = 1'b0;
        do_commit      = 1'b0;
        in_number      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!err_reg)
                    begin
                        unique case (phase_reg)
                            PH_EXPECT_A:
                            begin
                                if (is_digit)
                                begin
                                    start_next  = NUM_WIDTH'(digit_val);
                                    end_next    = NUM_WIDTH'(digit_val);
                                    stride_next = NUM_WIDTH'(1);
                                    junk_next   = 1'b0;
                                    phase_next  = PH_IN_A;
                                end
                                else
                                begin
                                    err_next = 1'b1;
                                end
                            end
                            PH_IN_A:
                            begin
                                priority if (char_byte == CH_COMMA)
                                begin
                                    comma_commit = 1'b1;
                                end
                                else if (char_byte == CH_DASH)
                                begin
                                    junk_next  = 1'b0;
                                    phase_next = PH_EXPECT_B;
                                end
                                else if (is_digit && !junk_reg)
                                begin
                                    start_next = acc_sat;
                                    end_next   = acc_sat;
                                end
                                else
                                begin
                                    junk_next = 1'b1;
                                end
                            end
                            PH_EXPECT_B:
                            begin
                                if (is_digit)
                                begin
                                    end_next   = NUM_WIDTH'(digit_val);
                                    phase_next = PH_IN_B;
                                end
                                else
                                begin
                                    err_next = 1'b1;
                                end
                            end
                            PH_IN_B:
                            begin
                                priority if (char_byte == CH_COMMA)
                                begin
                                    comma_commit = 1'b1;
                                end
                                else if (char_byte == CH_COLON)
                                begin
                                    junk_next  = 1'b0;
                                    phase_next = PH_EXPECT_S;
                                end
                                else if (is_digit && !junk_reg)
                                begin
                                    end_next = acc_sat;
                                end
                                else
                                begin
                                    junk_next = 1'b1;
                                end
                            end
                            PH_EXPECT_S:
                            begin
                                if (is_digit)
                                begin
                                    stride_next = NUM_WIDTH'(digit_val);
                                    phase_next  = PH_IN_S;
                                end
                                else
                                begin
                                    err_next = 1'b1;
                                end
                            end
                            PH_IN_S:
                            begin
                                priority if (char_byte == CH_COMMA)
                                begin
                                    comma_commit = 1'b1;
                                end
                                else if (is_digit && !junk_reg)
                                begin
                                    stride_next = acc_sat;
                                end
                                else
                                begin
                                    junk_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                err_next = 1'b1;
                            end
                        endcase
                    end

                    // comma closes the token
                    if (comma_commit)
                    begin
                        phase_next = PH_EXPECT_A;
                        junk_next  = 1'b0;
                        if (!last_char)
                        begin
                            do_commit = 1'b1;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end

                    in_number = (phase_next == PH_IN_A) || (phase_next == PH_IN_B) ||
                                (phase_next == PH_IN_S);

                    if (last_char && !err_next)
                    begin
                        if (!in_number || junk_next)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            do_commit = 1'b1;
                        end
                    end

                    final_next = last_char;

                    if (do_commit)
                    begin
                        if ((stride_next == '0) || (start_next > end_next))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            idx_next   = STP_W'(start_next);
                            state_next = S_WALK;
                        end
                    end

                    if (last_char && (state_next == S_IDLE))
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_WALK:
            begin
                if (in_range)
                begin
                    mask_next = mask_reg | (MASK_W'(1) << idx_reg[IDX_W-1:0]);
                    idx_next  = idx_sum;
                end
                else
                begin
                    state_next = final_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = !err_reg;
                    out_mask_next  = err_reg ? '0 : mask_reg;
                    state_next     = S_IDLE;
                    phase_next     = PH_EXPECT_A;
                    start_next     = '0;
                    end_next       = '0;
                    stride_next    = NUM_WIDTH'(1);
                    mask_next      = '0;
                    err_next       = 1'b0;
                    junk_next      = 1'b0;
                    final_next     = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign list_ok   = out_ok_reg;
    assign cpu_mask  = out_mask_reg;

endmodule

FILE: tb/cpu_list_to_bitmask_parser_tb.sv
// ----------------------------------------------------------------------------
// cpu_list_to_bitmask_parser_tb
// self-checking testbench for the cpu list to bit mask parser
//
// feeds cpu list strings one character per request and predicts list_ok and
// cpu_mask with its own parser model. a short directed part covers plain
// ranges, strides, saturation, large indices and several kinds of bad list.
// random lists follow: mostly well-formed tokens with random numbers, some
// corrupted by a replaced, inserted or dropped byte, and some pure noise.
// both sides idle in random bursts, except in the last part of the run.
// ----------------------------------------------------------------------------
module cpu_list_to_bitmask_parser_tb;
    import clbp_pkg::*;

    localparam int NUM_W    = 16;
    localparam int CPU_CNT  = 64;
    localparam int NUM_SAT  = (1 << NUM_W) - 1;

    typedef logic [7:0] char_q_t[$];

    typedef struct {
        logic              ok;
        logic [MASK_W-1:0] mask;
    } list_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        char_byte;
    logic              last_char;
    logic              out_valid;
    logic              out_ready;
    logic              list_ok;
    logic [MASK_W-1:0] cpu_mask;

    // parser model state
    phase_t            ph;
    logic [NUM_W-1:0]  lo_num;
    logic [NUM_W-1:0]  hi_num;
    logic [NUM_W-1:0]  stride_num;
    logic [MASK_W-1:0] listed_mask;
    logic              list_bad;
    logic              stray_after_num;

    list_result_t      pending_masks[$];
    list_result_t      next_result;
    int                mismatch_count = 0;
    int                chars_sent = 0;
    int                stall_cnt = 0;
    bit                idling_on = 1'b1;

    cpu_list_to_bitmask_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_byte (char_byte),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .list_ok   (list_ok),
        .cpu_mask  (cpu_mask)
    );

    always #10 clk = ~clk;

    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [NUM_W-1:0] sat_mac(input logic [NUM_W-1:0] v,
                                                 input logic [7:0] d);
        longint n;
        n = longint'(v) * RADIX + longint'(d);
        if (n > NUM_SAT)
            n = NUM_SAT;
        return n[NUM_W-1:0];
    endfunction

    function void clear_parse();
        ph              = PH_EXPECT_A;
        lo_num          = '0;
        hi_num          = '0;
        stride_num      = NUM_W'(1);
        listed_mask     = '0;
        list_bad        = 1'b0;
        stray_after_num = 1'b0;
    endfunction

    function void close_range();
        int idx;
        if (stride_num == 0 || lo_num > hi_num)
        begin
            list_bad = 1'b1;
        end
        else
        begin
            idx = int'(lo_num);
            while (idx <= int'(hi_num) && idx < CPU_CNT)
            begin
                listed_mask[6'(idx)] = 1'b1;
                idx += int'(stride_num);
            end
        end
        ph              = PH_EXPECT_A;
        stray_after_num = 1'b0;
    endfunction

    function void parse_char(input logic [7:0] c);
        logic       dig;
        logic [7:0] d;
        dig = (c >= CH_ZERO && c <= CH_NINE);
        d   = dig ? c - CH_ZERO : 8'd0;
        case (ph)
            PH_EXPECT_A:
            begin
                if (dig)
                begin
                    lo_num          = NUM_W'(d);
                    hi_num          = NUM_W'(d);
                    stride_num      = NUM_W'(1);
                    stray_after_num = 1'b0;
                    ph              = PH_IN_A;
                end
                else
                    list_bad = 1'b1;
            end
            PH_IN_A:
            begin
                if (c == CH_COMMA)
                    close_range();
                else if (c == CH_DASH)
                begin
                    stray_after_num = 1'b0;
                    ph              = PH_EXPECT_B;
                end
                else if (dig && !stray_after_num)
                begin
                    lo_num = sat_mac(lo_num, d);
                    hi_num = lo_num;
                end
                else
                    stray_after_num = 1'b1;
            end
            PH_EXPECT_B:
            begin
                if (dig)
                begin
                    hi_num = NUM_W'(d);
                    ph     = PH_IN_B;
                end
                else
                    list_bad = 1'b1;
            end
            PH_IN_B:
            begin
                if (c == CH_COMMA)
                    close_range();
                else if (c == CH_COLON)
                begin
                    stray_after_num = 1'b0;
                    ph              = PH_EXPECT_S;
                end
                else if (dig && !stray_after_num)
                    hi_num = sat_mac(hi_num, d);
                else
                    stray_after_num = 1'b1;
            end
            PH_EXPECT_S:
            begin
                if (dig)
                begin
                    stride_num = NUM_W'(d);
                    ph         = PH_IN_S;
                end
                else
                    list_bad = 1'b1;
            end
            PH_IN_S:
            begin
                if (c == CH_COMMA)
                    close_range();
                else if (dig && !stray_after_num)
                    stride_num = sat_mac(stride_num, d);
                else
                    stray_after_num = 1'b1;
            end
            default:
                list_bad = 1'b1;
        endcase
    endfunction

    function void predict_char(input logic [7:0] c, input logic last);
        list_result_t r;
        logic         junk;
        if (!list_bad)
            parse_char(c);
        if (last)
        begin
            if (!list_bad)
            begin
                if (ph == PH_IN_A || ph == PH_IN_B || ph == PH_IN_S)
                begin
                    junk = stray_after_num;
                    close_range();
                    if (junk)
                        list_bad = 1'b1;
                end
                else
                    list_bad = 1'b1;
            end
            r.ok   = !list_bad;
            r.mask = list_bad ? '0 : listed_mask;
            pending_masks.push_back(r);
            clear_parse();
        end
    endfunction

    // result check and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_masks.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual list_ok %0b cpu_mask %h",
                         $time, list_ok, cpu_mask);
                mismatch_count++;
            end
            else
            begin
                next_result = pending_masks.pop_front();
                if (list_ok !== next_result.ok)
                begin
                    $display("%0t: list_ok mismatch, expected %0b, actual %0b",
                             $time, next_result.ok, list_ok);
                    mismatch_count++;
                end
                if (cpu_mask !== next_result.mask)
                begin
                    $display("%0t: cpu_mask mismatch, expected %h, actual %h",
                             $time, next_result.mask, cpu_mask);
                    mismatch_count++;
                end
            end
        end
        if (stall_cnt > 0)
        begin
            stall_cnt = stall_cnt - 1;
            out_ready <= (stall_cnt == 0);
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            stall_cnt = $urandom_range(1, 19);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= c;
        last_char <= last;
        do @(posedge clk); while (!in_ready);
        predict_char(c, last);
        chars_sent++;
    endtask

    task automatic send_list(input char_q_t s);
        foreach (s[i])
            send_char(s[i], i == s.size() - 1);
    endtask

    task automatic send_text(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        send_list(q);
    endtask

    task automatic put_number(ref char_q_t q, input int n);
        string s;
        s = $sformatf("%0d", n);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endtask

    task automatic make_random_list(output char_q_t q);
        int         n_tok;
        int         lo;
        int         pos;
        logic [7:0] c;
        q = {};
        // pure noise
        if ($urandom_range(0, 11) == 0)
        begin
            repeat ($urandom_range(1, 6))
                q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n_tok = $urandom_range(1, 4);
        for (int t = 0; t < n_tok; t++)
        begin
            if (t != 0)
                q.push_back(CH_COMMA);
            lo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 999999)
                                              : $urandom_range(0, 70);
            put_number(q, lo);
            if ($urandom_range(0, 2) != 0)
            begin
                q.push_back(CH_DASH);
                if ($urandom_range(0, 9) == 0)
                    put_number(q, $urandom_range(0, 99999));
                else
                    put_number(q, lo + $urandom_range(0, 40));
                if ($urandom_range(0, 1) == 0)
                begin
                    q.push_back(CH_COLON);
                    case ($urandom_range(0, 11))
                        0:       put_number(q, 0);
                        1:       put_number(q, $urandom_range(0, 99999));
                        default: put_number(q, $urandom_range(1, 9));
                    endcase
                end
            end
        end
        // corrupt a fifth of the lists
        if ($urandom_range(0, 4) == 0)
        begin
            pos = $urandom_range(0, q.size() - 1);
            case ($urandom_range(0, 2))
                0: q[pos] = 8'($urandom_range(0, 255));
                1:
                begin
                    case ($urandom_range(0, 3))
                        0:       c = CH_COMMA;
                        1:       c = CH_DASH;
                        2:       c = CH_COLON;
                        default: c = 8'($urandom_range(0, 255));
                    endcase
                    q.insert(pos, c);
                end
                default:
                begin
                    if (q.size() > 1)
                        void'(q.pop_back());
                    else
                        q.push_back(CH_COMMA);
                end
            endcase
        end
    endtask

    task automatic test_valid_lists();
        send_text("0,2-9:7");
        send_text("99999");
    endtask

    task automatic test_error_lists();
        char_q_t q;
        send_text(",");
        send_text("2-1");
        send_text("0-9:0");
        send_text("3a");
        send_text("1:5,2-");
        // zero byte as a stray byte inside a token
        q = {8'h37, 8'h00, CH_COMMA, CH_ZERO};
        send_list(q);
    endtask

    task automatic test_random_lists();
        char_q_t q;
        while (chars_sent < 1350)
        begin
            make_random_list(q);
            send_list(q);
        end
    endtask

    task automatic test_no_idle_lists();
        char_q_t q;
        idling_on = 1'b0;
        while (chars_sent < 1530)
        begin
            make_random_list(q);
            send_list(q);
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        char_byte <= 8'd0;
        last_char <= 1'b0;
        out_ready <= 1'b0;
        clear_parse();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_valid_lists();
        test_error_lists();
        test_random_lists();
        test_no_idle_lists();
        in_valid <= 1'b0;
        while (pending_masks.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: cpu_list_to_bitmask_parser.f
hdl/clbp_pkg.sv
hdl/cpu_list_to_bitmask_parser.sv
tb/cpu_list_to_bitmask_parser_tb.sv
